// ----- hw/rtl/lob_pkg.sv -----
package lob_pkg;

  localparam int unsigned PRICE_W = 10;
  localparam int unsigned ID_W    = 10;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned DEPTH_W = 7;
  localparam int unsigned TOTAL_W = 42;
  localparam int unsigned ORDS_W  = 11;
  localparam int unsigned STAT_W  = 3;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_ERASE  = 2'd2;
  localparam logic [1:0] MODE_SNAP   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_PRICE = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_QTY   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_ID_LIVE   = 3'd4;

  typedef struct packed {
    logic [1:0]                mode;
    logic                      side;
    logic                      order_type;
    logic [ID_W-1:0]           order_id;
    logic [PRICE_W-1:0]        price;
    logic signed [QTY_W-1:0]   quantity;
    logic [DEPTH_W-1:0]        snapshot_depth;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PRICE_W-1:0] best_bid;
    logic               bid_valid;
    logic [PRICE_W-1:0] best_ask;
    logic               ask_valid;
    logic [PRICE_W-1:0] level_price;
    logic [TOTAL_W-1:0] level_quantity;
    logic [ORDS_W-1:0]  level_orders;
    logic               level_valid;
    logic               last;
  } out_req_t;

  typedef struct packed {
    logic               live;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-2:0]   qty;
  } slot_meta_t;

endpackage

// ----- hw/rtl/limit_order_book.sv -----
// Channel | Valid       | Stall       | Payload
// in      | in_valid_i  | in_stall_o  | in_req_i  (in_req_t)
// out     | out_valid_o | out_stall_i | out_req_o (out_req_t)
//
// One request at a time; cancel and erase remove an order, erase only the front one of its level.
// Removing the best level of a side rescans that side, reading and then checking one price level at a time.
// Snapshot walks price levels from the best one, reading and then checking each level visited.
// After reset a clearing pass runs over every entry of the level memories and the
// slot metadata memory; in_stall_o stays high meanwhile.
// A result waits in the output register while out_stall_i is high.
module limit_order_book
  import lob_pkg::*;
#(
  parameter int unsigned NUM_LEVELS   = 1024,
  parameter int unsigned MAX_ORDERS   = 1024,
  parameter int unsigned SNAPSHOT_MAX = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  localparam int unsigned LW    = $clog2(2 * NUM_LEVELS);
  localparam int unsigned SW    = $clog2(MAX_ORDERS);
  localparam int unsigned CW    = $clog2(MAX_ORDERS + 1);
  localparam int unsigned CLR_N = (2 * NUM_LEVELS > MAX_ORDERS) ? 2 * NUM_LEVELS : MAX_ORDERS;
  localparam int unsigned CLW   = $clog2(CLR_N);
  localparam logic [PRICE_W-1:0] TOP =
    PRICE_W'(((NUM_LEVELS < 1024) ? NUM_LEVELS : 1024) - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_ADD, S_CAN, S_ERS, S_UNL, S_SRD, S_SCHK, S_FLUSH, S_EMIT
  } state_e;

  function automatic logic [LW-1:0] lvl_idx(input logic s, input logic [PRICE_W-1:0] p);
    return s ? (LW'(NUM_LEVELS) + LW'(p)) : LW'(p);
  endfunction

  logic [SW-1:0]      lvl_head_mem [2*NUM_LEVELS];
  logic [SW-1:0]      lvl_tail_mem [2*NUM_LEVELS];
  logic [CW-1:0]      lvl_cnt_mem  [2*NUM_LEVELS];
  logic [TOTAL_W-1:0] lvl_tot_mem  [2*NUM_LEVELS];
  slot_meta_t         meta_mem     [MAX_ORDERS];
  logic [SW-1:0]      next_mem     [MAX_ORDERS];
  logic [SW-1:0]      prev_mem     [MAX_ORDERS];

  state_e state_q;
  in_req_t req_q;
  logic [STAT_W-1:0] status_q;
  logic [PRICE_W-1:0] bb_q, ba_q;
  logic bv_q, av_q;
  logic [CLW-1:0] clr_q;
  logic scan_side_q, snap_q;
  logic [PRICE_W-1:0] scan_p_q;
  logic [DEPTH_W-1:0] depth_q, found_q;
  logic pend_q;
  logic [PRICE_W-1:0] pend_p_q;
  logic [TOTAL_W-1:0] pend_tot_q;
  logic [CW-1:0] pend_cnt_q;
  out_req_t out_q;
  logic out_valid_q;

  logic               lvl_we, lvl_re;
  logic [LW-1:0]      lvl_waddr, lvl_raddr;
  logic [SW-1:0]      lvl_wh, lvl_wt;
  logic [CW-1:0]      lvl_wc;
  logic [TOTAL_W-1:0] lvl_wtot;
  logic [SW-1:0]      lvl_rh_q, lvl_rt_q;
  logic [CW-1:0]      lvl_rc_q;
  logic [TOTAL_W-1:0] lvl_rtot_q;

  logic               slot_re;
  logic [SW-1:0]      slot_raddr;
  logic               meta_we, next_we, prev_we;
  logic [SW-1:0]      meta_waddr, next_waddr, prev_waddr;
  slot_meta_t         meta_wdata;
  logic [SW-1:0]      next_wdata, prev_wdata;
  slot_meta_t         meta_rd_q;
  logic [SW-1:0]      next_rd_q, prev_rd_q;

  logic               emit;
  out_req_t           out_d;
  logic               out_free;

  logic [SW-1:0]      req_sid;
  logic [LW-1:0]      req_lv, meta_lv;
  logic               lvl_occ, emptied, end_hit;
  logic [PRICE_W-1:0] step_p;
  logic [DEPTH_W-1:0] depth_eff;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  assign req_sid  = SW'(req_q.order_id);
  assign req_lv   = lvl_idx(req_q.side, req_q.price);
  assign meta_lv  = lvl_idx(meta_rd_q.side, meta_rd_q.price);
  assign lvl_occ  = (lvl_rc_q != '0);
  assign emptied  = (lvl_rc_q <= CW'(1));
  assign end_hit  = scan_side_q ? (scan_p_q == TOP) : (scan_p_q == '0);
  assign step_p   = scan_side_q ? (scan_p_q + PRICE_W'(1)) : (scan_p_q - PRICE_W'(1));
  assign depth_eff = (req_q.snapshot_depth == '0 || 32'(req_q.snapshot_depth) > SNAPSHOT_MAX)
                     ? DEPTH_W'(SNAPSHOT_MAX) : req_q.snapshot_depth;

  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      lvl_head_mem[lvl_waddr] <= lvl_wh;
      lvl_tail_mem[lvl_waddr] <= lvl_wt;
      lvl_cnt_mem[lvl_waddr]  <= lvl_wc;
      lvl_tot_mem[lvl_waddr]  <= lvl_wtot;
    end
    if (lvl_re) begin
      lvl_rh_q   <= lvl_head_mem[lvl_raddr];
      lvl_rt_q   <= lvl_tail_mem[lvl_raddr];
      lvl_rc_q   <= lvl_cnt_mem[lvl_raddr];
      lvl_rtot_q <= lvl_tot_mem[lvl_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (slot_re) begin
      meta_rd_q <= meta_mem[slot_raddr];
      next_rd_q <= next_mem[slot_raddr];
      prev_rd_q <= prev_mem[slot_raddr];
    end
  end

  always_comb begin
    lvl_we = 1'b0; lvl_re = 1'b0;
    lvl_waddr = '0; lvl_raddr = '0;
    lvl_wh = '0; lvl_wt = '0; lvl_wc = '0; lvl_wtot = '0;
    slot_re = 1'b0; slot_raddr = '0;
    meta_we = 1'b0; meta_waddr = '0; meta_wdata = '0;
    next_we = 1'b0; next_waddr = '0; next_wdata = '0;
    prev_we = 1'b0; prev_waddr = '0; prev_wdata = '0;
    case (state_q)
      S_CLR: begin
        lvl_we     = (32'(clr_q) < 2 * NUM_LEVELS);
        lvl_waddr  = LW'(clr_q);
        meta_we    = (32'(clr_q) < MAX_ORDERS);
        meta_waddr = SW'(clr_q);
      end
      S_DEC: begin
        slot_re    = (req_q.mode != MODE_SNAP);
        slot_raddr = req_sid;
        lvl_re     = (req_q.mode == MODE_ADD) || (req_q.mode == MODE_ERASE);
        lvl_raddr  = req_lv;
      end
      S_ADD: begin
        if (!meta_rd_q.live) begin
          meta_we    = 1'b1;
          meta_waddr = req_sid;
          meta_wdata = '{live: 1'b1, side: req_q.side, price: req_q.price,
                         qty: req_q.quantity[QTY_W-2:0]};
          prev_we    = 1'b1;
          prev_waddr = req_sid;
          prev_wdata = lvl_occ ? lvl_rt_q : '0;
          next_we    = lvl_occ;
          next_waddr = lvl_rt_q;
          next_wdata = req_sid;
          lvl_we     = 1'b1;
          lvl_waddr  = req_lv;
          lvl_wh     = lvl_occ ? lvl_rh_q : req_sid;
          lvl_wt     = req_sid;
          lvl_wc     = lvl_occ ? (lvl_rc_q + CW'(1)) : CW'(1);
          lvl_wtot   = (lvl_occ ? lvl_rtot_q : '0) + TOTAL_W'(req_q.quantity[QTY_W-2:0]);
        end
      end
      S_CAN: begin
        lvl_re    = 1'b1;
        lvl_raddr = meta_lv;
      end
      S_UNL: begin
        meta_we      = 1'b1;
        meta_waddr   = req_sid;
        meta_wdata   = meta_rd_q;
        meta_wdata.live = 1'b0;
        lvl_we       = 1'b1;
        lvl_waddr    = meta_lv;
        if (emptied) begin
          lvl_wh = lvl_rh_q;
          lvl_wt = lvl_rt_q;
        end else begin
          lvl_wh     = (lvl_rh_q == req_sid) ? next_rd_q : lvl_rh_q;
          lvl_wt     = (lvl_rt_q == req_sid) ? prev_rd_q : lvl_rt_q;
          lvl_wc     = lvl_rc_q - CW'(1);
          lvl_wtot   = lvl_rtot_q - TOTAL_W'(meta_rd_q.qty);
          next_we    = (lvl_rh_q != req_sid);
          next_waddr = prev_rd_q;
          next_wdata = next_rd_q;
          prev_we    = (lvl_rt_q != req_sid);
          prev_waddr = next_rd_q;
          prev_wdata = prev_rd_q;
        end
      end
      S_SRD: begin
        lvl_re    = 1'b1;
        lvl_raddr = lvl_idx(scan_side_q, scan_p_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    emit  = 1'b0;
    out_d = '{status: status_q, best_bid: bb_q, bid_valid: bv_q, best_ask: ba_q,
              ask_valid: av_q, level_price: '0, level_quantity: '0, level_orders: '0,
              level_valid: 1'b0, last: 1'b1};
    case (state_q)
      S_EMIT: emit = 1'b1;
      S_SCHK: begin
        if (snap_q && lvl_occ && pend_q) begin
          emit = 1'b1;
          out_d.status         = ST_OK;
          out_d.level_price    = pend_p_q;
          out_d.level_quantity = pend_tot_q;
          out_d.level_orders   = ORDS_W'(pend_cnt_q);
          out_d.level_valid    = 1'b1;
          out_d.last           = 1'b0;
        end
      end
      S_FLUSH: begin
        emit = 1'b1;
        out_d.status         = ST_OK;
        out_d.level_price    = pend_p_q;
        out_d.level_quantity = pend_tot_q;
        out_d.level_orders   = ORDS_W'(pend_cnt_q);
        out_d.level_valid    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      req_q       <= '0;
      status_q    <= ST_OK;
      bb_q        <= '0;
      bv_q        <= 1'b0;
      ba_q        <= '0;
      av_q        <= 1'b0;
      clr_q       <= '0;
      scan_side_q <= 1'b0;
      snap_q      <= 1'b0;
      scan_p_q    <= '0;
      depth_q     <= '0;
      found_q     <= '0;
      pend_q      <= 1'b0;
      pend_p_q    <= '0;
      pend_tot_q  <= '0;
      pend_cnt_q  <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= emit;
        if (emit) out_q <= out_d;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + CLW'(1);
          if (32'(clr_q) == CLR_N - 1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_req_i;
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          status_q <= ST_OK;
          case (req_q.mode)
            MODE_ADD: begin
              if ((!req_q.order_type && req_q.price == '0) ||
                  32'(req_q.price) >= NUM_LEVELS) begin
                status_q <= ST_BAD_PRICE;
                state_q  <= S_EMIT;
              end else if (req_q.quantity <= 0) begin
                status_q <= ST_BAD_QTY;
                state_q  <= S_EMIT;
              end else if (32'(req_q.order_id) >= MAX_ORDERS) begin
                status_q <= ST_NOT_FOUND;
                state_q  <= S_EMIT;
              end else begin
                state_q <= S_ADD;
              end
            end
            MODE_CANCEL: begin
              if (32'(req_q.order_id) >= MAX_ORDERS) begin
                status_q <= ST_NOT_FOUND;
                state_q  <= S_EMIT;
              end else begin
                state_q <= S_CAN;
              end
            end
            MODE_ERASE: begin
              if (32'(req_q.price) >= NUM_LEVELS || 32'(req_q.order_id) >= MAX_ORDERS) begin
                status_q <= ST_NOT_FOUND;
                state_q  <= S_EMIT;
              end else begin
                state_q <= S_ERS;
              end
            end
            default: begin
              snap_q      <= 1'b1;
              scan_side_q <= req_q.side;
              scan_p_q    <= req_q.side ? ba_q : bb_q;
              depth_q     <= depth_eff;
              found_q     <= '0;
              pend_q      <= 1'b0;
              if (req_q.side ? av_q : bv_q) state_q <= S_SRD;
              else state_q <= S_EMIT;
            end
          endcase
        end
        S_ADD: begin
          if (meta_rd_q.live) begin
            status_q <= ST_ID_LIVE;
          end else if (!req_q.side) begin
            if (!bv_q || req_q.price > bb_q) begin
              bb_q <= req_q.price;
              bv_q <= 1'b1;
            end
          end else begin
            if (!av_q || req_q.price < ba_q) begin
              ba_q <= req_q.price;
              av_q <= 1'b1;
            end
          end
          state_q <= S_EMIT;
        end
        S_CAN: begin
          if (!meta_rd_q.live) begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_UNL;
          end
        end
        S_ERS: begin
          if (!lvl_occ || lvl_rh_q != req_sid || !meta_rd_q.live) begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_UNL;
          end
        end
        S_UNL: begin
          state_q     <= S_EMIT;
          snap_q      <= 1'b0;
          scan_side_q <= meta_rd_q.side;
          if (emptied && !meta_rd_q.side && bv_q && bb_q == meta_rd_q.price) begin
            if (meta_rd_q.price == '0) begin
              bb_q <= '0;
              bv_q <= 1'b0;
            end else begin
              scan_p_q <= meta_rd_q.price - PRICE_W'(1);
              state_q  <= S_SRD;
            end
          end else if (emptied && meta_rd_q.side && av_q && ba_q == meta_rd_q.price) begin
            if (meta_rd_q.price == TOP) begin
              ba_q <= '0;
              av_q <= 1'b0;
            end else begin
              scan_p_q <= meta_rd_q.price + PRICE_W'(1);
              state_q  <= S_SRD;
            end
          end
        end
        S_SRD: state_q <= S_SCHK;
        S_SCHK: begin
          if (!snap_q) begin
            if (lvl_occ) begin
              if (scan_side_q) begin
                ba_q <= scan_p_q;
                av_q <= 1'b1;
              end else begin
                bb_q <= scan_p_q;
                bv_q <= 1'b1;
              end
              state_q <= S_EMIT;
            end else if (end_hit) begin
              if (scan_side_q) begin
                ba_q <= '0;
                av_q <= 1'b0;
              end else begin
                bb_q <= '0;
                bv_q <= 1'b0;
              end
              state_q <= S_EMIT;
            end else begin
              scan_p_q <= step_p;
              state_q  <= S_SRD;
            end
          end else if (lvl_occ) begin
            if (!pend_q || out_free) begin
              pend_q     <= 1'b1;
              pend_p_q   <= scan_p_q;
              pend_tot_q <= lvl_rtot_q;
              pend_cnt_q <= lvl_rc_q;
              found_q    <= found_q + DEPTH_W'(1);
              if (found_q + DEPTH_W'(1) == depth_q || end_hit) begin
                state_q <= S_FLUSH;
              end else begin
                scan_p_q <= step_p;
                state_q  <= S_SRD;
              end
            end
          end else if (end_hit) begin
            state_q <= S_FLUSH;
          end else begin
            scan_p_q <= step_p;
            state_q  <= S_SRD;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            pend_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/lob_checker.sv -----
`timescale 1ns / 100ps

module lob_checker
  import lob_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  in_req_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  out_req_t out_req_i,
  output int       fail_count_o,
  output int       pending_o
);

  localparam int unsigned LEVELS = 1024;
  localparam int unsigned SNAP_MAX = 64;

  int unsigned        book_q[2*LEVELS][$];
  logic [TOTAL_W-1:0] level_sum[2*LEVELS];
  logic               order_live[1024];
  logic [QTY_W-2:0]   order_qty[1024];
  int unsigned        order_level[1024];
  out_req_t           expected_q[$];
  int                 fails;

  function automatic void clear_book();
    for (int i = 0; i < 2*LEVELS; i++) begin
      book_q[i].delete();
      level_sum[i] = '0;
    end
    for (int i = 0; i < 1024; i++) order_live[i] = 1'b0;
    expected_q.delete();
    fails = 0;
  endfunction

  function automatic void remove_order(int unsigned id);
    int unsigned lv;
    lv = order_level[id];
    for (int i = 0; i < book_q[lv].size(); i++) begin
      if (book_q[lv][i] == id) begin
        book_q[lv].delete(i);
        break;
      end
    end
    level_sum[lv] = level_sum[lv] - order_qty[id];
    order_live[id] = 1'b0;
  endfunction

  task automatic predict_book(input in_req_t r);
    logic [STAT_W-1:0] st;
    out_req_t res;
    int unsigned lv, id, depth, n, pr;
    st = ST_OK;
    id = r.order_id;
    lv = r.side * LEVELS + r.price;
    case (r.mode)
      MODE_ADD: begin
        if (!r.order_type && r.price == 0) st = ST_BAD_PRICE;
        else if (r.quantity <= 0) st = ST_BAD_QTY;
        else if (order_live[id]) st = ST_ID_LIVE;
        else begin
          order_live[id] = 1'b1;
          order_qty[id] = r.quantity[QTY_W-2:0];
          order_level[id] = lv;
          book_q[lv].insert(book_q[lv].size(), id);
          level_sum[lv] = level_sum[lv] + r.quantity[QTY_W-2:0];
        end
      end
      MODE_CANCEL: begin
        if (!order_live[id]) st = ST_NOT_FOUND;
        else remove_order(id);
      end
      MODE_ERASE: begin
        if (book_q[lv].size() == 0 || book_q[lv][0] != id || !order_live[id])
          st = ST_NOT_FOUND;
        else remove_order(id);
      end
      default: ;
    endcase
    res = '0;
    res.status = st;
    for (int p = LEVELS - 1; p >= 0; p--) begin
      if (book_q[p].size() != 0) begin
        res.best_bid = PRICE_W'(p);
        res.bid_valid = 1'b1;
        break;
      end
    end
    for (int p = 0; p < LEVELS; p++) begin
      if (book_q[LEVELS + p].size() != 0) begin
        res.best_ask = PRICE_W'(p);
        res.ask_valid = 1'b1;
        break;
      end
    end
    if (r.mode != MODE_SNAP) begin
      res.last = 1'b1;
      expected_q.insert(expected_q.size(), res);
    end else begin
      depth = r.snapshot_depth;
      if (depth == 0 || depth > SNAP_MAX) depth = SNAP_MAX;
      n = 0;
      for (int i = 0; i < LEVELS && n < depth; i++) begin
        pr = r.side ? i : LEVELS - 1 - i;
        lv = r.side * LEVELS + pr;
        if (book_q[lv].size() == 0) continue;
        res.level_price = PRICE_W'(pr);
        res.level_quantity = level_sum[lv];
        res.level_orders = ORDS_W'(book_q[lv].size());
        res.level_valid = 1'b1;
        res.last = 1'b0;
        expected_q.insert(expected_q.size(), res);
        n++;
      end
      if (n == 0) begin
        res.last = 1'b1;
        expected_q.insert(expected_q.size(), res);
      end else begin
        expected_q[expected_q.size() - 1].last = 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    out_req_t e;
    if (!rst_ni) begin
      clear_book();
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_book(in_req_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_req_i);
          fails++;
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          check_field("status", e.status, out_req_i.status);
          check_field("best_bid", e.best_bid, out_req_i.best_bid);
          check_field("bid_valid", e.bid_valid, out_req_i.bid_valid);
          check_field("best_ask", e.best_ask, out_req_i.best_ask);
          check_field("ask_valid", e.ask_valid, out_req_i.ask_valid);
          check_field("level_price", e.level_price, out_req_i.level_price);
          check_field("level_quantity", e.level_quantity, out_req_i.level_quantity);
          check_field("level_orders", e.level_orders, out_req_i.level_orders);
          check_field("level_valid", e.level_valid, out_req_i.level_valid);
          check_field("last", e.last, out_req_i.last);
        end
      end
      pending_o <= expected_q.size();
      fail_count_o <= fails + expected_q.size();
    end
  end

endmodule

// ----- bench/tb_limit_order_book.sv -----
`timescale 1ns / 100ps

module tb_limit_order_book;
  import lob_pkg::*;

  localparam int REQ_W = $bits(in_req_t);

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;
  int       fail_count;
  int       pending;

  int tx_idle_pct;
  int rx_idle_pct;
  logic rx_hold_go;
  logic rx_hold_taken = 1'b0;
  int rx_hold_cycles = 0;

  int unsigned live_ids[$];
  logic        id_side[1024];
  logic [9:0]  id_price[1024];

  limit_order_book uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  lob_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_req_i   (out_req),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver side stalls
  always @(posedge clk_i) begin
    if (rx_hold_go && !rx_hold_taken) begin
      rx_hold_taken <= 1'b1;
      rx_hold_cycles <= 400;
      out_stall <= 1'b1;
    end else if (rx_hold_cycles > 0) begin
      out_stall <= 1'b1;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic in_req_t mk(input logic [1:0] mode, input int unsigned side,
                                 input int unsigned mkt, input int unsigned id,
                                 input int unsigned price, input logic [31:0] qty,
                                 input int unsigned depth);
    in_req_t r;
    r.mode = mode;
    r.side = 1'(side);
    r.order_type = 1'(mkt);
    r.order_id = ID_W'(id);
    r.price = PRICE_W'(price);
    r.quantity = qty;
    r.snapshot_depth = DEPTH_W'(depth);
    return r;
  endfunction

  function automatic int find_live(input int unsigned id);
    foreach (live_ids[i]) if (live_ids[i] == id) return i;
    return -1;
  endfunction

  // follow which ids rest in the book, to aim cancels and erases
  function automatic void track(input in_req_t r);
    int k;
    k = find_live(r.order_id);
    case (r.mode)
      MODE_ADD: begin
        if (k < 0 && !(!r.order_type && r.price == 0) && r.quantity > 0) begin
          live_ids.insert(live_ids.size(), r.order_id);
          id_side[r.order_id] = r.side;
          id_price[r.order_id] = r.price;
        end
      end
      MODE_CANCEL: if (k >= 0) live_ids.delete(k);
      MODE_ERASE: begin
        foreach (live_ids[i]) begin
          if (id_side[live_ids[i]] == r.side && id_price[live_ids[i]] == r.price) begin
            if (live_ids[i] == r.order_id) live_ids.delete(i);
            break;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(input in_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    track(r);
  endtask

  task automatic drain_book_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic in_req_t random_req();
    int unsigned pick, id;
    logic side;
    pick = $urandom_range(99);
    side = 1'($urandom_range(1));
    if (pick < 45) begin
      id = $urandom_range(1023);
      return mk(MODE_ADD, side, $urandom_range(9) == 0, id,
                side ? $urandom_range(12, 1) : $urandom_range(1023, 1010),
                $urandom_range(1, 32'h7fff_ffff), 0);
    end else if (pick < 65 && live_ids.size() != 0) begin
      return mk(MODE_CANCEL, side, 0, live_ids[$urandom_range(live_ids.size() - 1)],
                $urandom, $urandom, $urandom);
    end else if (pick < 80 && live_ids.size() != 0) begin
      id = live_ids[$urandom_range(live_ids.size() - 1)];
      return mk(MODE_ERASE, id_side[id], $urandom, id, id_price[id], $urandom, $urandom);
    end else if (pick < 90) begin
      return mk(MODE_SNAP, side, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(127));
    end
    return in_req_t'(REQ_W'({$urandom, $urandom}));
  endfunction

  initial begin
    in_req_t dir[$];
    in_valid = 1'b0;
    in_req = '0;
    rst_ni = 1'b0;
    tx_idle_pct = 21;
    rx_idle_pct = 49;
    rx_hold_go = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir.insert(dir.size(), mk(MODE_SNAP, 0, 0, 0, 0, 0, 0));
    dir.insert(dir.size(), mk(MODE_SNAP, 1, 0, 0, 0, 0, 64));
    dir.insert(dir.size(), mk(MODE_ADD, 0, 0, 5, 0, 100, 0));
    dir.insert(dir.size(), mk(MODE_ADD, 1, 1, 6, 0, 100, 0));
    dir.insert(dir.size(), mk(MODE_ADD, 0, 0, 7, 20, 0, 0));
    dir.insert(dir.size(), mk(MODE_ADD, 0, 0, 7, 20, 32'hffff_ffff, 0));
    dir.insert(dir.size(), mk(MODE_ADD, 0, 0, 7, 20, 32'h8000_0000, 0));
    dir.insert(dir.size(), mk(MODE_ADD, 0, 0, 1023, 1023, 32'h7fff_ffff, 0));
    dir.insert(dir.size(), mk(MODE_ADD, 0, 0, 0, 1023, 32'h7fff_ffff, 0));
    dir.insert(dir.size(), mk(MODE_ADD, 0, 0, 8, 1023, 1, 0));
    dir.insert(dir.size(), mk(MODE_ADD, 1, 0, 1023, 1, 5, 0));
    dir.insert(dir.size(), mk(MODE_ADD, 1, 0, 9, 1023, 7, 0));
    dir.insert(dir.size(), mk(MODE_ADD, 0, 0, 10, 1, 3, 0));
    dir.insert(dir.size(), mk(MODE_SNAP, 0, 0, 0, 0, 0, 1));
    dir.insert(dir.size(), mk(MODE_SNAP, 1, 0, 0, 0, 0, 127));
    dir.insert(dir.size(), mk(MODE_CANCEL, 0, 0, 500, 0, 0, 0));
    dir.insert(dir.size(), mk(MODE_ERASE, 0, 0, 8, 1023, 0, 0));
    dir.insert(dir.size(), mk(MODE_ERASE, 0, 0, 3, 400, 0, 0));
    dir.insert(dir.size(), mk(MODE_CANCEL, 0, 0, 0, 0, 0, 0));
    dir.insert(dir.size(), mk(MODE_ERASE, 0, 0, 1023, 1023, 0, 0));
    dir.insert(dir.size(), mk(MODE_CANCEL, 1, 0, 6, 0, 0, 0));
    dir.insert(dir.size(), mk(MODE_ERASE, 1, 0, 1023, 1, 0, 0));
    dir.insert(dir.size(), mk(MODE_SNAP, 0, 0, 0, 0, 0, 65));
    foreach (dir[i]) send_req(dir[i]);
    drain_book_results();

    for (int i = 0; i < 160; i++) begin
      if (i == 53) begin
        tx_idle_pct = 49;
        rx_idle_pct = 21;
        rx_hold_go = 1'b1;
      end
      if (i == 107) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_req(random_req());
    end
    drain_book_results();
    repeat (3000) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lob_pkg.sv
hw/rtl/limit_order_book.sv
bench/lob_checker.sv
bench/tb_limit_order_book.sv
